[hdl/crc8cfp_pkg.sv]
// ----------------------------------------------------------------------------
// crc8cfp_pkg
// shared types, constants and the byte-wide crc-8 update for the frame parser
// ----------------------------------------------------------------------------
package crc8cfp_pkg;

    localparam int unsigned FRAME_LEN = 7;
    localparam int unsigned CRC_LEN   = 6;
    localparam int unsigned POS_W     = 3;

    localparam logic [7:0] CRC_POLY_REFL = 8'h18;
    localparam logic [7:0] CRC_TOP_BIT   = 8'h80;
    localparam logic [7:0] CRC_LSB       = 8'h01;
    localparam logic [7:0] HDR0          = 8'h59;  // 'Y'
    localparam logic [7:0] HDR1          = 8'h4C;  // 'L'
    localparam logic [7:0] CMD_BYTE      = 8'h52;

    localparam logic [POS_W-1:0] POS_HDR0  = 3'd0;
    localparam logic [POS_W-1:0] POS_HDR1  = 3'd1;
    localparam logic [POS_W-1:0] POS_CMD   = 3'd2;
    localparam logic [POS_W-1:0] POS_DIR   = 3'd3;
    localparam logic [POS_W-1:0] POS_SPDHI = 3'd4;
    localparam logic [POS_W-1:0] POS_SPDLO = 3'd5;
    localparam logic [POS_W-1:0] POS_CRC   = POS_W'(CRC_LEN);

    localparam int unsigned OUT_TDATA_W = 24;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_CRC_ERR   = 3'd1,
        ST_BAD_HDR   = 3'd2,
        ST_BAD_CMD   = 3'd3,
        ST_BAD_DIR   = 3'd4
    } t_status;

    typedef struct packed {
        logic [15:0] target_speed;
        logic        direction;
        t_status     status;
    } t_result;

    // reflected crc-8, dallas/maxim form, one input byte per call
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic [7:0] d;
        c = crc;
        d = b;
        for (int k = 0; k < 8; k++) begin
            if (((c ^ d) & CRC_LSB) == 8'd0) begin
                c = c >> 1;
            end else begin
                c = ((c ^ CRC_POLY_REFL) >> 1) | CRC_TOP_BIT;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

[hdl/crc8cfp_frame.sv]
// ----------------------------------------------------------------------------
// crc8cfp_frame
// per-frame state: byte position, running crc, check flags, held command
// ----------------------------------------------------------------------------
module crc8cfp_frame (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic [7:0]            i_byte,
    output logic                  o_last,
    output crc8cfp_pkg::t_result  o_result
);

    logic [crc8cfp_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0] r_crc, n_crc;
    logic       r_hdr_bad, n_hdr_bad;
    logic       r_cmd_bad, n_cmd_bad;
    logic [7:0] r_dir_byte, n_dir_byte;
    logic [7:0] r_spd_hi, n_spd_hi;
    logic [7:0] r_spd_lo, n_spd_lo;
    logic       r_held_dir, n_held_dir;
    logic [15:0] r_held_spd, n_held_spd;
    crc8cfp_pkg::t_status status;

    // positions past the crc byte cannot occur from reset, treated as last
    assign o_last = (r_pos >= crc8cfp_pkg::POS_CRC);

    always_comb begin
        if (r_crc != i_byte) begin
            status = crc8cfp_pkg::ST_CRC_ERR;
        end else if (r_hdr_bad) begin
            status = crc8cfp_pkg::ST_BAD_HDR;
        end else if (r_cmd_bad) begin
            status = crc8cfp_pkg::ST_BAD_CMD;
        end else if (r_dir_byte > 8'd1) begin
            status = crc8cfp_pkg::ST_BAD_DIR;
        end else begin
            status = crc8cfp_pkg::ST_ACCEPTED;
        end
    end

    always_comb begin
        o_result.status = status;
        if (status == crc8cfp_pkg::ST_ACCEPTED) begin
            o_result.direction    = r_dir_byte[0];
            o_result.target_speed = {r_spd_hi, r_spd_lo};
        end else begin
            o_result.direction    = r_held_dir;
            o_result.target_speed = r_held_spd;
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_hdr_bad  = r_hdr_bad;
        n_cmd_bad  = r_cmd_bad;
        n_dir_byte = r_dir_byte;
        n_spd_hi   = r_spd_hi;
        n_spd_lo   = r_spd_lo;
        n_held_dir = r_held_dir;
        n_held_spd = r_held_spd;
        if (i_advance) begin
            if (o_last) begin
                n_pos      = '0;
                n_crc      = '0;
                n_hdr_bad  = 1'b0;
                n_cmd_bad  = 1'b0;
                n_held_dir = o_result.direction;
                n_held_spd = o_result.target_speed;
            end else begin
                n_pos = r_pos + 1'b1;
                n_crc = crc8cfp_pkg::crc8_update(r_crc, i_byte);
                case (r_pos)
                    crc8cfp_pkg::POS_HDR0: begin
                        if (i_byte != crc8cfp_pkg::HDR0) n_hdr_bad = 1'b1;
                    end
                    crc8cfp_pkg::POS_HDR1: begin
                        if (i_byte != crc8cfp_pkg::HDR1) n_hdr_bad = 1'b1;
                    end
                    crc8cfp_pkg::POS_CMD: begin
                        if (i_byte != crc8cfp_pkg::CMD_BYTE) n_cmd_bad = 1'b1;
                    end
                    crc8cfp_pkg::POS_DIR: begin
                        n_dir_byte = i_byte;
                    end
                    crc8cfp_pkg::POS_SPDHI: begin
                        n_spd_hi = i_byte;
                    end
                    default: begin
                        n_spd_lo = i_byte;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_crc      <= '0;
            r_hdr_bad  <= 1'b0;
            r_cmd_bad  <= 1'b0;
            r_dir_byte <= '0;
            r_spd_hi   <= '0;
            r_spd_lo   <= '0;
            r_held_dir <= 1'b0;
            r_held_spd <= '0;
        end else begin
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_hdr_bad  <= n_hdr_bad;
            r_cmd_bad  <= n_cmd_bad;
            r_dir_byte <= n_dir_byte;
            r_spd_hi   <= n_spd_hi;
            r_spd_lo   <= n_spd_lo;
            r_held_dir <= n_held_dir;
            r_held_spd <= n_held_spd;
        end
    end

endmodule

[hdl/crc8cfp_out.sv]
// ----------------------------------------------------------------------------
// crc8cfp_out
// result register, holds one result until the downstream takes it
// ----------------------------------------------------------------------------
module crc8cfp_out (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  crc8cfp_pkg::t_result  i_result,
    input  logic                  i_ready,
    output logic                  o_can_load,
    output logic                  o_valid,
    output crc8cfp_pkg::t_result  o_result
);

    logic                 r_valid, n_valid;
    crc8cfp_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[hdl/crc8_checked_command_frame_parser.sv]
// ----------------------------------------------------------------------------
// crc8_checked_command_frame_parser
// checks 7-byte command frames with a crc-8 and reports status per frame
// ----------------------------------------------------------------------------
// usage:
//   slave stream takes one received byte per transaction; bytes are grouped
//   into fixed 7-byte frames counted from reset, no resynchronisation
//   master stream gives one result per frame, on the seventh byte: status,
//   direction and target speed of the last accepted command
//   a byte is held in an input register, then the crc step, checks and
//   frame state update run combinationally into the result register
//   path: input register, then result register, to o_m_axis_tvalid
//   throughput: one byte per cycle unless the result register stalls
//   reset clears the frame position, crc, flags and the held command
//   when the receiver stalls, the result register holds; the input register
//   still drains bytes 0..5 of the next frame, and the seventh byte waits
//   there, so o_s_axis_tready drops only once both are full
// ----------------------------------------------------------------------------
module crc8_checked_command_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] data_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata   // [2:0] status, [3] direction,
                                         // [19:4] target_speed, [23:20] zero
);

    logic                 r_in_valid, n_in_valid;
    logic [7:0]           r_in_byte;
    logic                 in_accept;
    logic                 advance;
    logic                 frame_last;
    logic                 out_can_load;
    logic                 out_valid;
    crc8cfp_pkg::t_result frame_result;
    crc8cfp_pkg::t_result out_result;

    assign advance         = r_in_valid && (!frame_last || out_can_load);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    crc8cfp_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(advance),
        .i_byte   (r_in_byte),
        .o_last   (frame_last),
        .o_result (frame_result)
    );

    crc8cfp_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (advance && frame_last),
        .i_result  (frame_result),
        .i_ready   (i_m_axis_tready),
        .o_can_load(out_can_load),
        .o_valid   (out_valid),
        .o_result  (out_result)
    );

    assign o_m_axis_tvalid = out_valid;
    assign o_m_axis_tdata  = {4'd0, out_result.target_speed, out_result.direction,
                              out_result.status};

    // an empty input register always takes a byte
    a_in_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_s_axis_tready)
        else $error("input register empty but not ready");

    // a frame's last byte always lands in the result register
    a_last_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && frame_last) |=> o_m_axis_tvalid)
        else $error("last byte did not produce a result");

    // status code stays within the defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[2:0] <= crc8cfp_pkg::ST_BAD_DIR))
        else $error("status code out of range");

    // an accepted frame reports the target speed it just carried
    a_accept_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && frame_last && frame_result.status == crc8cfp_pkg::ST_ACCEPTED)
        |=> (o_m_axis_tdata[19:4] == $past(frame_result.target_speed)))
        else $error("accepted frame speed mismatch");

endmodule
